>>> hw/rtl/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long press and repeat.
// No dependencies.
package bdlp_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned PIN_W    = 5;                  // pins carried in one word
    localparam int unsigned EV_SLOTS = 5;                  // button codes carried out
    localparam int unsigned EV_W     = EV_SLOTS * CODE_W;  // 15
    localparam int unsigned IDX_W    = 2;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CFG_W-1:0]  t_ms;

    // Event codes
    localparam t_code EV_NONE     = 3'd0;
    localparam t_code EV_PRESSED  = 3'd1;
    localparam t_code EV_RELEASED = 3'd2;
    localparam t_code EV_LONG     = 3'd3;
    localparam t_code EV_REPEAT   = 3'd4;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_REPEAT_DELAY = 2'd2;
    localparam logic [IDX_W-1:0] CFG_REPEAT_RATE  = 2'd3;

    // Reset values of the timing registers
    localparam t_ms RST_DEBOUNCE     = 16'd30;
    localparam t_ms RST_LONG_PRESS   = 16'd800;
    localparam t_ms RST_REPEAT_DELAY = 16'd400;
    localparam t_ms RST_REPEAT_RATE  = 16'd120;

    typedef struct packed {
        t_ms debounce_ms;
        t_ms long_press_ms;
        t_ms repeat_delay_ms;
        t_ms repeat_rate_ms;
    } t_cfg;

    // Lane control from the top level
    typedef struct packed {
        logic  step;   // sample word accepted
        logic  clear;  // clear word accepted
        t_time now;
    } t_lane_ctl;

endpackage

>>> hw/rtl/button_debounce_long_press_repeat.sv
// Top level: button debouncer with long press and auto repeat, one lane per button.
// Depends on bdlp_pkg, bdlp_lane, bdlp_merge.
//
//  Channel   Dir  Handshake              Payload
//  --------  ---  ---------------------  ------------------------------------------
//  s_axis    in   tvalid / tready        tdata: now_ms[31:0], pin_levels[36:32]
//                                        tuser: clear_all
//  m_axis    out  tvalid / tready        tdata: event_codes[14:0]
//  cfg       in   valid / ready          index (0..3), data (16 bits)
//
//  One word per clock while m_axis takes its results. Every lane updates its
//  state at the accepting edge and the merge stage registers the packed codes,
//  so a result appears in the cycle after its word is taken. The output register
//  frees itself the same cycle it is read, so s_axis only stalls while m_axis
//  holds a word back. Reset is synchronous, active low; it loads the default
//  timings and clears all lanes. Config writes are always taken.
module button_debounce_long_press_repeat #(
    parameter int unsigned BUTTONS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [39:0]                   i_s_axis_tdata,   // now_ms[31:0], pin_levels[36:32]
    input  logic [0:0]                    i_s_axis_tuser,   // clear_all[0]
    // event stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [15:0]                   o_m_axis_tdata,   // event_codes[14:0]
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bdlp_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]    i_cfg_data
);
    import bdlp_pkg::*;

    t_cfg              r_cfg;
    t_lane_ctl         lane_ctl;
    t_code [BUTTONS-1:0] codes;
    logic              room;
    logic              accept;
    logic [PIN_W-1:0]  pins;
    logic [EV_W-1:0]   events;

    // Timing registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= RST_DEBOUNCE;
            r_cfg.long_press_ms   <= RST_LONG_PRESS;
            r_cfg.repeat_delay_ms <= RST_REPEAT_DELAY;
            r_cfg.repeat_rate_ms  <= RST_REPEAT_RATE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:     r_cfg.debounce_ms     <= i_cfg_data;
                CFG_LONG_PRESS:   r_cfg.long_press_ms   <= i_cfg_data;
                CFG_REPEAT_DELAY: r_cfg.repeat_delay_ms <= i_cfg_data;
                CFG_REPEAT_RATE:  r_cfg.repeat_rate_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake: take a word whenever the output register has room
    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;
    assign pins            = i_s_axis_tdata[TIME_W +: PIN_W];

    assign lane_ctl.now   = i_s_axis_tdata[TIME_W-1:0];
    assign lane_ctl.step  = accept && !i_s_axis_tuser[0];
    assign lane_ctl.clear = accept && i_s_axis_tuser[0];

    // Lanes; buttons without a pin read as released
    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        logic raw;
        if (g < PIN_W) begin : g_pin
            assign raw = !pins[g];
        end else begin : g_nopin
            assign raw = 1'b0;
        end

        bdlp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_cfg   (r_cfg),
            .i_raw   (raw),
            .o_code  (codes[g])
        );
    end

    bdlp_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_clear  (i_s_axis_tuser[0]),
        .i_codes  (codes),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_events (events)
    );

    assign o_m_axis_tdata = {1'b0, events};

endmodule

>>> hw/rtl/bdlp_lane.sv
// One button lane: raw edge tracking, debounce, long press and auto repeat.
// Depends on bdlp_pkg.
module bdlp_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdlp_pkg::t_lane_ctl i_ctl,
    input  bdlp_pkg::t_cfg     i_cfg,
    input  logic               i_raw,    // 1 = pressed
    output bdlp_pkg::t_code    o_code
);
    import bdlp_pkg::*;

    logic  r_deb, r_prev, r_lp_done;
    t_time r_edge_t, r_press_t, r_rep_t;

    logic  n_deb, n_prev, n_lp_done;
    t_time n_edge_t, n_press_t, n_rep_t;

    t_time edge_t, since_edge, hold, since_rep;
    logic  deb_ok, change, long_hit, rep_hit;
    t_code code;

    always_comb begin
        edge_t     = (i_raw != r_prev) ? i_ctl.now : r_edge_t;
        since_edge = i_ctl.now - edge_t;
        hold       = i_ctl.now - r_press_t;
        since_rep  = i_ctl.now - r_rep_t;
        deb_ok     = since_edge >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms};
        change     = deb_ok && (i_raw != r_deb);
        long_hit   = !r_lp_done && (hold >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms});
        rep_hit    = (hold >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.repeat_delay_ms})
                  && (since_rep >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.repeat_rate_ms});

        n_deb     = r_deb;
        n_prev    = i_raw;
        n_edge_t  = edge_t;
        n_press_t = r_press_t;
        n_rep_t   = r_rep_t;
        n_lp_done = r_lp_done;
        code      = EV_NONE;

        priority if (change) begin
            n_deb = i_raw;
            if (i_raw) begin
                n_press_t = i_ctl.now;
                n_rep_t   = i_ctl.now;
                n_lp_done = 1'b0;
                code      = EV_PRESSED;
            end else begin
                code = EV_RELEASED;
            end
        end else if (!r_deb) begin
            code = EV_NONE;
        end else if (long_hit) begin
            n_lp_done = 1'b1;
            code      = EV_LONG;
        end else if (rep_hit) begin
            n_rep_t = i_ctl.now;
            code    = EV_REPEAT;
        end else begin
            code = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb     <= 1'b0;
            r_prev    <= 1'b0;
            r_lp_done <= 1'b0;
            r_edge_t  <= '0;
            r_press_t <= '0;
            r_rep_t   <= '0;
        end else if (i_ctl.clear) begin
            r_deb     <= 1'b0;
            r_prev    <= 1'b0;
            r_lp_done <= 1'b0;
            r_edge_t  <= i_ctl.now;
            r_press_t <= '0;
            r_rep_t   <= '0;
        end else if (i_ctl.step) begin
            r_deb     <= n_deb;
            r_prev    <= n_prev;
            r_lp_done <= n_lp_done;
            r_edge_t  <= n_edge_t;
            r_press_t <= n_press_t;
            r_rep_t   <= n_rep_t;
        end
    end

    assign o_code = code;

endmodule

>>> hw/rtl/bdlp_merge.sv
// Merge stage: packs lane codes into the result word and holds it in the output register.
// Depends on bdlp_pkg.
module bdlp_merge #(
    parameter int unsigned BUTTONS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,    // word accepted this cycle
    input  logic                              i_clear,   // accepted word is a clear
    input  bdlp_pkg::t_code [BUTTONS-1:0]     i_codes,
    output logic                              o_room,    // output register can take a word
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [bdlp_pkg::EV_W-1:0]         o_events
);
    import bdlp_pkg::*;

    logic            r_valid;
    logic [EV_W-1:0] r_events;
    logic [EV_W-1:0] merged;

    for (genvar g = 0; g < EV_SLOTS; g++) begin : g_slot
        if (g < BUTTONS) begin : g_on
            assign merged[g*CODE_W +: CODE_W] = i_clear ? EV_NONE : i_codes[g];
        end else begin : g_off
            assign merged[g*CODE_W +: CODE_W] = EV_NONE;
        end
    end

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_events <= merged;
        end
    end

    assign o_valid  = r_valid;
    assign o_events = r_events;

endmodule
